// ----- hw/rtl/usart_8251_register_model_core_defines.svh -----
// Assertion macros shared by the checker of the USART register model.
// No dependencies; included by files that write concurrent assertions.
`ifndef USART_8251_REGISTER_MODEL_CORE_DEFINES_SVH
`define USART_8251_REGISTER_MODEL_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define USART_ASSERT_IMPLY(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define USART_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- hw/rtl/usart8251_pkg.sv -----
// Types, codes and constants of the 8251-style USART register model.
// No dependencies; imported by the core and its checker.
package usart8251_pkg;

  // Bus access kinds.
  localparam logic [2:0] MODE_RESET    = 3'd0;
  localparam logic [2:0] MODE_CTRL_WR  = 3'd1;
  localparam logic [2:0] MODE_DATA_WR  = 3'd2;
  localparam logic [2:0] MODE_RX_BYTE  = 3'd3;
  localparam logic [2:0] MODE_STAT_RD  = 3'd4;
  localparam logic [2:0] MODE_DATA_RD  = 3'd5;

  // Control-write sequencer states.
  localparam logic [2:0] LINE_AWAIT_MODE = 3'd0;
  localparam logic [2:0] LINE_SYNC_CHAR1 = 3'd1;
  localparam logic [2:0] LINE_SYNC_CHAR2 = 3'd2;
  localparam logic [2:0] LINE_SYNC       = 3'd3;
  localparam logic [2:0] LINE_ASYNC      = 3'd4;

  // Status bits and command/mode bits.
  localparam logic [7:0] ST_RESET   = 8'h05;
  localparam logic [7:0] ST_RXRDY   = 8'h02;
  localparam logic [7:0] ST_OE      = 8'h10;
  localparam logic [7:0] ST_ERRORS  = 8'h38;
  localparam logic [7:0] CMD_IRESET = 8'h40;
  localparam logic [7:0] CMD_ERRCLR = 8'h10;
  localparam logic [7:0] CMD_RXE    = 8'h04;
  localparam logic [7:0] CMD_TXEN   = 8'h01;
  localparam logic [7:0] MODE_PEN   = 8'h10;
  localparam logic [7:0] MODE_EVEN  = 8'h20;

  localparam logic [1:0] PARITY_NONE = 2'd0;
  localparam logic [1:0] PARITY_ODD  = 2'd1;
  localparam logic [1:0] PARITY_EVEN = 2'd2;

  localparam int unsigned BASE_CLOCK = 1200 * 64;
  localparam int BAUD_W = 17;
  localparam logic [3:0] LEN_RESET = 4'd5;

  // Baud value for each rate field; field 0 selects sync mode instead.
  localparam logic [BAUD_W-1:0] BAUD_TABLE [4] = '{
    BAUD_W'(BASE_CLOCK / 1), BAUD_W'(BASE_CLOCK / 1),
    BAUD_W'(BASE_CLOCK / 16), BAUD_W'(BASE_CLOCK / 64)
  };

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] data_byte;
  } access_t;

  typedef struct packed {
    logic [7:0]        read_data;
    logic              raise_rx_interrupt;
    logic              lower_request;
    logic [BAUD_W-1:0] async_baud;
    logic [3:0]        char_bits;
    logic [1:0]        parity_kind;
    logic [1:0]        stop_code;
    logic [2:0]        line_mode;
    logic              rx_enabled;
    logic              tx_enabled;
  } result_t;

  function automatic logic [1:0] parity_of(input logic [7:0] d);
    if ((d & MODE_PEN) == 8'h00) begin
      return PARITY_NONE;
    end
    return ((d & MODE_EVEN) != 8'h00) ? PARITY_EVEN : PARITY_ODD;
  endfunction

endpackage

// ----- hw/rtl/usart_8251_register_model_core.sv -----
// Top level of the 8251-style USART register model: state update and result queue.
// Depends on usart8251_pkg.
//
//   channel   | valid         | stall         | payload
//   ----------+---------------+---------------+-------------------------
//   access    | access_valid  | access_stall  | access (access_t)
//   result    | result_valid  | result_stall  | result (result_t)
//
// Every accepted access yields exactly one result, computed in the same cycle
// from the current registers and registered; one access per cycle is sustained
// while access_stall is low. A result register backed by a one-entry skid
// register decouples the two sides, so an access is still taken while a result
// waits. access_stall rises only when both entries hold results. Reset is
// synchronous and restores the power-up register values and empty queues.
module usart_8251_register_model_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   access_valid,
  output logic                   access_stall,
  input  usart8251_pkg::access_t access,
  output logic                   result_valid,
  input  logic                   result_stall,
  output usart8251_pkg::result_t result
);
  import usart8251_pkg::*;

  // Architectural registers of the USART.
  logic [2:0]        line_state, line_state_next;
  logic [7:0]        status_bits, status_bits_next;
  logic [7:0]        held_byte, held_byte_next;
  logic [BAUD_W-1:0] baud_value, baud_value_next;
  logic [3:0]        length_bits, length_bits_next;
  logic [1:0]        parity_setting, parity_setting_next;
  logic [1:0]        stop_setting, stop_setting_next;
  logic              receive_on, receive_on_next;
  logic              transmit_on, transmit_on_next;

  logic [7:0] read_next;
  logic       irq_next;
  logic       lower_next;
  result_t    result_next;

  // Output queue: the visible result register plus a skid entry.
  result_t skid;
  logic    skid_valid;

  logic accept;
  logic take;
  logic [7:0] d;

  assign d            = access.data_byte;
  assign access_stall = skid_valid;
  assign accept       = access_valid && !access_stall;
  assign take         = result_valid && !result_stall;

  // Next register values for the access on the port.
  always_comb begin
    line_state_next     = line_state;
    status_bits_next    = status_bits;
    held_byte_next      = held_byte;
    baud_value_next     = baud_value;
    length_bits_next    = length_bits;
    parity_setting_next = parity_setting;
    stop_setting_next   = stop_setting;
    receive_on_next     = receive_on;
    transmit_on_next    = transmit_on;
    read_next           = 8'h00;
    irq_next            = 1'b0;
    lower_next          = 1'b0;

    unique case (access.mode)
      MODE_RESET: begin
        // Software reset keeps the settings, enables and held byte.
        line_state_next  = LINE_AWAIT_MODE;
        status_bits_next = ST_RESET;
      end
      MODE_CTRL_WR: begin
        unique case (line_state) inside
          LINE_AWAIT_MODE: begin
            if (d[1:0] != 2'b00) begin
              line_state_next     = LINE_ASYNC;
              baud_value_next     = BAUD_TABLE[d[1:0]];
              length_bits_next    = LEN_RESET + {2'b00, d[3:2]};
              parity_setting_next = parity_of(d);
              stop_setting_next   = d[7:6];
            end else begin
              // A sync mode instruction leaves length and stop code alone.
              line_state_next     = LINE_SYNC_CHAR1;
              baud_value_next     = '0;
              parity_setting_next = parity_of(d);
            end
          end
          LINE_SYNC_CHAR1: line_state_next = LINE_SYNC_CHAR2;
          LINE_SYNC_CHAR2: line_state_next = LINE_SYNC;
          LINE_SYNC, LINE_ASYNC: begin
            if ((d & CMD_IRESET) != 8'h00) begin
              line_state_next = LINE_AWAIT_MODE;
            end else begin
              if ((d & CMD_ERRCLR) != 8'h00) begin
                status_bits_next = status_bits & ~ST_ERRORS;
              end
              receive_on_next  = (d & CMD_RXE) != 8'h00;
              transmit_on_next = (d & CMD_TXEN) != 8'h00;
            end
          end
          default: line_state_next = LINE_AWAIT_MODE;
        endcase
      end
      MODE_RX_BYTE: begin
        if (receive_on) begin
          held_byte_next = d;
          // A byte landing on an unread one flags an overrun.
          if ((status_bits & ST_RXRDY) != 8'h00) begin
            status_bits_next = status_bits | ST_OE | ST_RXRDY;
          end else begin
            status_bits_next = status_bits | ST_RXRDY;
          end
          irq_next = 1'b1;
        end
      end
      MODE_STAT_RD: read_next = status_bits;
      MODE_DATA_RD: begin
        lower_next       = (status_bits & ST_RXRDY) != 8'h00;
        status_bits_next = status_bits & ~ST_RXRDY;
        read_next        = held_byte;
      end
      default: begin
        // Data writes and the unused codes change nothing.
      end
    endcase
  end

  // The result reports the settings as they stand after the access.
  always_comb begin
    result_next.read_data          = read_next;
    result_next.raise_rx_interrupt = irq_next;
    result_next.lower_request      = lower_next;
    result_next.async_baud         = baud_value_next;
    result_next.char_bits          = length_bits_next;
    result_next.parity_kind        = parity_setting_next;
    result_next.stop_code          = stop_setting_next;
    result_next.line_mode          = line_state_next;
    result_next.rx_enabled         = receive_on_next;
    result_next.tx_enabled         = transmit_on_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_state     <= LINE_AWAIT_MODE;
      status_bits    <= ST_RESET;
      held_byte      <= 8'h00;
      baud_value     <= '0;
      length_bits    <= LEN_RESET;
      parity_setting <= PARITY_NONE;
      stop_setting   <= 2'd0;
      receive_on     <= 1'b0;
      transmit_on    <= 1'b0;
    end else if (accept) begin
      line_state     <= line_state_next;
      status_bits    <= status_bits_next;
      held_byte      <= held_byte_next;
      baud_value     <= baud_value_next;
      length_bits    <= length_bits_next;
      parity_setting <= parity_setting_next;
      stop_setting   <= stop_setting_next;
      receive_on     <= receive_on_next;
      transmit_on    <= transmit_on_next;
    end
  end

  // Result queue control. While the skid entry is full no access is taken,
  // so at most one of the two paths into the queue is active in a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (result_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        result_valid <= 1'b1;
      end
    end else if (take) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        result <= skid;
      end
    end else if (accept) begin
      if (result_valid && !take) begin
        skid <= result_next;
      end else begin
        result <= result_next;
      end
    end
  end

endmodule

// ----- hw/rtl/usart8251_checker.sv -----
// Port-level checker for the USART register model, bound to the core below.
// Depends on usart8251_pkg and usart_8251_register_model_core_defines.svh.
`include "usart_8251_register_model_core_defines.svh"

module usart8251_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   access_valid,
  input logic                   access_stall,
  input usart8251_pkg::access_t access,
  input logic                   result_valid,
  input logic                   result_stall,
  input usart8251_pkg::result_t result
);
  import usart8251_pkg::*;

  logic sync_line;
  assign sync_line = (result.line_mode == LINE_SYNC_CHAR1) ||
                     (result.line_mode == LINE_SYNC_CHAR2) ||
                     (result.line_mode == LINE_SYNC);

  // A received byte and a data read are different accesses.
  `USART_ASSERT_IMPLY(a_one_flag, clk, rst, result_valid,
    !(result.raise_rx_interrupt && result.lower_request),
    "interrupt raise and request drop in one result")

  // Sync mode always reports a zero baud value.
  `USART_ASSERT_IMPLY(a_sync_baud, clk, rst, result_valid && sync_line,
    result.async_baud == '0, "nonzero baud value in sync mode")

  // Character length stays in the 5 to 8 range.
  `USART_ASSERT_IMPLY(a_len_range, clk, rst, result_valid,
    (result.char_bits >= 4'd5) && (result.char_bits <= 4'd8),
    "character length out of range")

  // A stalled result is held until it is taken.
  `USART_ASSERT_NEXT(a_hold, clk, rst, result_valid && result_stall,
    result_valid && $stable(result), "stalled result changed or dropped")

  // A stalled access is held by the sender until it transfers.
  `USART_ASSERT_NEXT(a_access_hold, clk, rst, access_valid && access_stall,
    access_valid && $stable(access), "stalled access changed or withdrawn")

endmodule

bind usart_8251_register_model_core usart8251_checker u_checker (.*);
